[rtl/core/deq_pkg.sv]
package deq_pkg;

    // Number of ring entries (legal range 2 to 64).
    localparam int DEQ_DEPTH = 32;
    // Ring index width.
    localparam int DEQ_AW = (DEQ_DEPTH > 1) ? $clog2(DEQ_DEPTH) : 1;
    // Width of a count that can hold DEQ_DEPTH itself.
    localparam int DEQ_CW = $clog2(DEQ_DEPTH + 1);
    // Width of an index plus an offset before the ring wrap.
    localparam int DEQ_SW = $clog2(2 * DEQ_DEPTH);
    // Stored word width.
    localparam int DEQ_VW = 31;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_REAR  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_PRINT      = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        STAT_POPPED    = 3'd0,
        STAT_PRINTED   = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_UNDERFLOW = 3'd3,
        STAT_OVERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [DEQ_AW-1:0] addr;
        logic [DEQ_VW-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic [DEQ_VW-1:0] value;
        logic [2:0]        status;
        logic              last;
    } result_t;

endpackage

[rtl/core/deq_ram.sv]
module deq_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                             wdata,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/deq_slot.sv]
module deq_slot
    import deq_pkg::*;
(
    input  logic [DEQ_AW-1:0] base,
    input  logic [DEQ_CW-1:0] offset,
    output logic [DEQ_AW-1:0] slot
);

    logic [DEQ_SW-1:0] sum;

    // The offset is always below the depth, so one conditional subtract wraps the sum.
    always_comb begin
        sum = DEQ_SW'(base) + DEQ_SW'(offset);
        if (sum >= DEQ_SW'(DEQ_DEPTH)) begin
            sum = sum - DEQ_SW'(DEQ_DEPTH);
        end
        slot = sum[DEQ_AW-1:0];
    end

endmodule

[rtl/core/deq_ctrl.sv]
module deq_ctrl
    import deq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        in_action,
    input  logic [DEQ_VW-1:0] in_value,
    output ram_req_t          ram_req,
    input  logic [DEQ_VW-1:0] ram_rdata,
    output logic              res_valid,
    output result_t           res,
    input  logic              res_ready
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [DEQ_AW-1:0] front_reg, front_next;
    logic [DEQ_CW-1:0] occ_reg, occ_next;
    logic [DEQ_CW-1:0] idx_reg, idx_next;
    logic [2:0]        stat_reg, stat_next;
    logic              use_ram_reg, use_ram_next;
    logic              print_reg, print_next;
    logic              last_reg, last_next;

    logic [DEQ_CW-1:0] offset;
    logic [DEQ_AW-1:0] slot;
    logic              full;
    logic              empty;

    deq_slot u_slot (
        .base   (front_reg),
        .offset (offset),
        .slot   (slot)
    );

    assign full  = (occ_reg == DEQ_CW'(DEQ_DEPTH));
    assign empty = (occ_reg == '0);

    always_comb begin
        state_next   = state_reg;
        front_next   = front_reg;
        occ_next     = occ_reg;
        idx_next     = idx_reg;
        stat_next    = stat_reg;
        use_ram_next = use_ram_reg;
        print_next   = print_reg;
        last_next    = last_reg;
        offset       = '0;
        ram_req      = '0;
        ram_req.addr  = slot;
        ram_req.wdata = in_value;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    use_ram_next = 1'b0;
                    print_next   = 1'b0;
                    last_next    = 1'b1;
                    case (in_action)
                        ACT_PUSH_FRONT: begin
                            if (full) begin
                                stat_next  = STAT_OVERFLOW;
                                state_next = S_EMIT;
                            end else begin
                                offset     = DEQ_CW'(DEQ_DEPTH - 1);
                                ram_req.we = 1'b1;
                                front_next = slot;
                                occ_next   = occ_reg + 1'b1;
                            end
                        end
                        ACT_PUSH_REAR: begin
                            if (full) begin
                                stat_next  = STAT_OVERFLOW;
                                state_next = S_EMIT;
                            end else begin
                                offset     = occ_reg;
                                ram_req.we = 1'b1;
                                occ_next   = occ_reg + 1'b1;
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (empty) begin
                                stat_next = STAT_UNDERFLOW;
                            end else begin
                                // Read the old front while the unit advances it.
                                offset       = DEQ_CW'(1);
                                ram_req.re   = 1'b1;
                                ram_req.addr = front_reg;
                                front_next   = slot;
                                occ_next     = occ_reg - 1'b1;
                                stat_next    = STAT_POPPED;
                                use_ram_next = 1'b1;
                            end
                            state_next = S_EMIT;
                        end
                        ACT_POP_REAR: begin
                            if (empty) begin
                                stat_next = STAT_UNDERFLOW;
                            end else begin
                                offset       = occ_reg - 1'b1;
                                ram_req.re   = 1'b1;
                                occ_next     = occ_reg - 1'b1;
                                stat_next    = STAT_POPPED;
                                use_ram_next = 1'b1;
                            end
                            state_next = S_EMIT;
                        end
                        ACT_PRINT: begin
                            if (empty) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                ram_req.re   = 1'b1;
                                idx_next     = '0;
                                stat_next    = STAT_PRINTED;
                                use_ram_next = 1'b1;
                                print_next   = 1'b1;
                                last_next    = (occ_reg == DEQ_CW'(1));
                            end
                            state_next = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (res_ready) begin
                    if (print_reg && !last_reg) begin
                        // Fetch the next entry while the current one moves out.
                        offset     = idx_reg + 1'b1;
                        ram_req.re = 1'b1;
                        idx_next   = idx_reg + 1'b1;
                        last_next  = ((idx_reg + DEQ_CW'(2)) == occ_reg);
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            occ_reg     <= '0;
            idx_reg     <= '0;
            stat_reg    <= '0;
            use_ram_reg <= 1'b0;
            print_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            occ_reg     <= occ_next;
            idx_reg     <= idx_next;
            stat_reg    <= stat_next;
            use_ram_reg <= use_ram_next;
            print_reg   <= print_next;
            last_reg    <= last_next;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_EMIT);
    assign res.value  = use_ram_reg ? ram_rdata : '0;
    assign res.status = stat_reg;
    assign res.last   = last_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= DEQ_CW'(DEQ_DEPTH))
        else $error("occupancy exceeds depth");

    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        front_reg <= DEQ_AW'(DEQ_DEPTH - 1))
        else $error("front index outside ring");

    a_occ_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (occ_reg == $past(occ_reg) || occ_reg == $past(occ_reg) + 1'b1
             || occ_reg == $past(occ_reg) - 1'b1))
        else $error("occupancy moved by more than one");

    a_no_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_req.we && ram_req.re))
        else $error("read and write in the same cycle");

    a_push_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |=> (state_reg == S_IDLE))
        else $error("successful push produced a result");
`endif

endmodule

[rtl/core/double_ended_queue_unit.sv]
// Bounded double-ended queue of 31-bit words held in a ring of DEQ_DEPTH entries.
// Input transactions arrive on the s_ channel: s_tuser carries the action (push front,
// push rear, pop front, pop rear, print) and s_tdata the word to push.
// Result transactions leave on the m_ channel: m_tdata carries the popped or printed
// word, m_tuser the status code and m_tlast marks the final result of an action.
// A successful push produces no result; s_tready stays high.
// A pop, or a failed push or pop, produces one result. The RAM read runs at the accepting
// edge; the result passes through the S_EMIT state and then the output register, and
// s_tready returns as m_tvalid rises, so a new input waits until that result is registered.
// A print streams the held words front to rear, one per cycle while m_tready is
// high, since the sequencer fetches the next entry while the current one moves out.
// The ring index adder is one shared unit used for every pointer update and for every address but the pop-front read.
// s_tready is low from the acceptance of a result-producing action until its last
// result has entered the output register. A stall on m_tready holds the output
// register and the sequencer; no result is dropped or repeated.
// Reset empties the queue and clears the front index; stored words are not cleared
// and are never read before being written.
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] push_value, [31] zero
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] value, [31] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    ram_req_t          ram_req;
    logic [DEQ_VW-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              m_valid_reg;
    result_t           m_res_reg;

    deq_ram #(
        .WIDTH (DEQ_VW),
        .DEPTH (DEQ_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    deq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_value  (s_tdata[DEQ_VW-1:0]),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // The output register takes a new result when empty or when its current
    // transaction completes in this cycle.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.value};
    assign m_tuser  = m_res_reg.status;
    assign m_tlast  = m_res_reg.last;

endmodule

[tb/sv/double_ended_queue_unit_tb.sv]
`timescale 1ns / 100ps

module double_ended_queue_unit_tb;
    import deq_pkg::*;

    // Number of cycles the receiver refuses results during the back-pressure test.
    localparam int HOLD_CYCLES = 300;
    // Input transactions that do real work (push, pop, print) before the run winds down.
    localparam int ITEM_TARGET = 180;
    // Quiet time after the last expected result.
    // It covers a full print plus the read pipeline, so a stray result still gets caught.
    localparam int DRAIN_CYCLES = 48;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIX
    } phase_t;

    // Shadow copy of the deque. Each accepted input transaction updates it, and the
    // results that the block must return are queued in order.
    class deque_mirror;
        bit [DEQ_VW-1:0] ring [DEQ_DEPTH];
        bit [DEQ_AW-1:0] head;
        bit [DEQ_CW-1:0] fill;
        result_t         pending_results [$];
        int              mismatches;

        function new();
            head = '0;
            fill = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void add_expected(bit [DEQ_VW-1:0] value, status_t status, bit last);
            result_t r;
            r.value  = value;
            r.status = status;
            r.last   = last;
            pending_results.push_back(r);
        endfunction

        function void take_action(logic [2:0] act, logic [DEQ_VW-1:0] word);
            case (act)
                ACT_PUSH_FRONT: begin
                    if (fill == DEQ_DEPTH) begin
                        add_expected('0, STAT_OVERFLOW, 1'b1);
                    end else begin
                        head = DEQ_AW'((int'(head) + DEQ_DEPTH - 1) % DEQ_DEPTH);
                        ring[head] = word;
                        fill++;
                    end
                end
                ACT_PUSH_REAR: begin
                    if (fill == DEQ_DEPTH) begin
                        add_expected('0, STAT_OVERFLOW, 1'b1);
                    end else begin
                        ring[(int'(head) + int'(fill)) % DEQ_DEPTH] = word;
                        fill++;
                    end
                end
                ACT_POP_FRONT: begin
                    if (fill == 0) begin
                        add_expected('0, STAT_UNDERFLOW, 1'b1);
                    end else begin
                        add_expected(ring[head], STAT_POPPED, 1'b1);
                        head = DEQ_AW'((int'(head) + 1) % DEQ_DEPTH);
                        fill--;
                    end
                end
                ACT_POP_REAR: begin
                    if (fill == 0) begin
                        add_expected('0, STAT_UNDERFLOW, 1'b1);
                    end else begin
                        add_expected(ring[(int'(head) + int'(fill) - 1) % DEQ_DEPTH],
                                     STAT_POPPED, 1'b1);
                        fill--;
                    end
                end
                ACT_PRINT: begin
                    if (fill == 0) begin
                        add_expected('0, STAT_EMPTY, 1'b1);
                    end else begin
                        for (int i = 0; i < int'(fill); i++) begin
                            add_expected(ring[(int'(head) + i) % DEQ_DEPTH], STAT_PRINTED,
                                         i == int'(fill) - 1);
                        end
                    end
                end
                default: begin
                    // Unused action codes leave the deque alone and return nothing.
                end
            endcase
        endfunction

        // Output is capped so that a badly broken block cannot flood the log.
        // Every mismatch is still counted.
        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 50) begin
                $display("MISMATCH at %0t ns: %s", $time, what);
            end
        endtask

        task match_result(logic [31:0] tdata, logic [2:0] tuser, logic tlast);
            result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result data=%h status=%0d last=%b",
                                          tdata, tuser, tlast));
                return;
            end
            want = pending_results.pop_front();
            if (tdata !== {1'b0, want.value}) begin
                report_mismatch($sformatf("data %h, expected %h", tdata, {1'b0, want.value}));
            end
            if (tuser !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d", tuser, want.status));
            end
            if (tlast !== want.last) begin
                report_mismatch($sformatf("last %b, expected %b", tlast, want.last));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [30:0] push_value, [31] zero
    logic [2:0]  s_tuser;    // [2:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [30:0] value, [31] zero
    logic [2:0]  m_tuser;    // [2:0] status
    logic        m_tlast;

    deque_mirror mirror = new();

    // The stimulus sets hold_off_req; the receiver sets hold_active once the stall has begun
    // and clears both flags when it ends.
    bit hold_off_req = 1'b0;
    bit hold_active  = 1'b0;

    double_ended_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The run ends here if it gets stuck. The limit lies far beyond what the slowest
    // correct run would need.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result transactions are checked at the rising edge, where the handshake completes.
    // All inputs change on the falling edge, so these samples never race with the drivers.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            mirror.match_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // The receiver mostly takes results in runs, with short stalls and an occasional long one.
    // On request it holds off for a fixed number of cycles, so that the block has to fill up
    // and push back on its input.
    initial begin : receiver
        int  pick;
        int  span;
        bit  level;
        m_tready = 1'b0;
        forever begin
            if (hold_off_req) begin
                @(negedge aclk);
                m_tready    = 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_active  = 1'b0;
                hold_off_req = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    level = 1'b1;
                    span  = $urandom_range(1, 24);
                end else if (pick < 92) begin
                    level = 1'b0;
                    span  = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    span  = $urandom_range(12, 40);
                end
                repeat (span) begin
                    @(negedge aclk);
                    m_tready = level;
                end
            end
        end
    end

    // Random pause before the next input transaction. Most pauses are zero or short, and a
    // few are long.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Words to push. The two extremes come up often, and the rest are spread over the whole
    // 31-bit range.
    function automatic logic [DEQ_VW-1:0] pick_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return DEQ_VW'($urandom());
    endfunction

    // Drop s_tvalid for the given number of cycles, and drive junk on the data lines meanwhile.
    task automatic idle_input(int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tuser  = 3'($urandom());
            s_tdata  = {1'b0, DEQ_VW'($urandom())};
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // Present one input transaction and wait until it is accepted. s_tvalid stays high
    // afterwards, so back-to-back calls produce a continuous stream. The mirror is updated
    // as soon as the block accepts the transaction.
    task automatic offer_action(logic [2:0] act, logic [DEQ_VW-1:0] word);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {1'b0, word};
        do @(posedge aclk); while (s_tready !== 1'b1);
        mirror.take_action(act, word);
    endtask

    // Wait with the input idle until every predicted result has come back.
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (mirror.pending() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int         counted;
        int         in_phase;
        int         hits;
        int         phase_no;
        int         pick;
        bit         gappy;
        bit         done;
        phase_t     mode;
        logic [2:0] act;
        int         push_cut;
        int         pop_cut;
        int         print_cut;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = ACT_PUSH_FRONT;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. It exercises the empty-queue errors and the index wrap on a push at
        // the front, and it checks a print of several words and of a single one. The all-ones
        // word is popped at the front and zero at the rear, and unused codes must be ignored.
        offer_action(ACT_PRINT, '0);
        offer_action(ACT_POP_FRONT, '0);
        offer_action(ACT_POP_REAR, '1);
        offer_action(ACT_PUSH_FRONT, '1);
        idle_input(pick_gap());
        offer_action(ACT_PUSH_REAR, '0);
        offer_action(ACT_PUSH_FRONT, 31'h2AAA_AAAA);
        offer_action(ACT_PUSH_REAR, 31'h5555_5555);
        offer_action(3'd5, '1);
        offer_action(3'd6, 31'h1234_5678);
        offer_action(3'd7, '0);
        offer_action(ACT_PRINT, '0);
        idle_input(pick_gap());
        offer_action(ACT_POP_FRONT, '0);
        offer_action(ACT_POP_REAR, '0);
        offer_action(ACT_POP_REAR, '0);
        offer_action(ACT_POP_FRONT, '0);
        offer_action(ACT_POP_FRONT, '0);
        offer_action(ACT_PUSH_REAR, 31'd1);
        offer_action(ACT_PRINT, '0);
        offer_action(ACT_POP_REAR, '0);
        counted = 16;

        // Random part. The phases are biased in turn: fill until pushes overflow, drain until
        // pops underflow, then a mix. Each fill and drain phase runs until it has hit its
        // limit twice after at least 25 items, or until 70 items.
        phase_no = 0;
        while (counted < ITEM_TARGET) begin
            mode  = phase_t'(phase_no % 3);
            gappy = ($urandom_range(0, 3) != 0);

            if (phase_no == 1) begin
                // Back-pressure test. The receiver holds off while the sender streams with no
                // gaps. The first action that needs a result has to wait for it, so the block
                // must drop s_tready. The input is idle while the stall gets going, so the
                // last transaction is not offered twice.
                idle_input(1);
                hold_off_req = 1'b1;
                while (!hold_active) @(posedge aclk);
                gappy = 1'b0;
            end
            if (phase_no == 2) begin
                wait_results_drained();
            end

            case (mode)
                PH_FILL: begin
                    push_cut  = 80;
                    pop_cut   = 92;
                    print_cut = 97;
                end
                PH_DRAIN: begin
                    push_cut  = 12;
                    pop_cut   = 86;
                    print_cut = 96;
                end
                default: begin
                    push_cut  = 42;
                    pop_cut   = 82;
                    print_cut = 96;
                end
            endcase

            in_phase = 0;
            hits     = 0;
            done     = 1'b0;
            while (counted < ITEM_TARGET && !done) begin
                pick = $urandom_range(0, 99);
                if (pick < push_cut) begin
                    act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
                    if (mode == PH_FILL && mirror.fill == DEQ_DEPTH) begin
                        hits++;
                    end
                end else if (pick < pop_cut) begin
                    act = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
                    if (mode == PH_DRAIN && mirror.fill == 0) begin
                        hits++;
                    end
                end else if (pick < print_cut) begin
                    act = ACT_PRINT;
                end else begin
                    act = 3'($urandom_range(5, 7));
                end

                offer_action(act, pick_word());
                if (act <= ACT_PRINT) begin
                    counted++;
                    in_phase++;
                end
                if (gappy) begin
                    idle_input(pick_gap());
                end
                done = (in_phase >= 70) || (in_phase >= 25 && (mode == PH_MIX || hits >= 2));
            end
            phase_no++;
        end

        // Wind down. Lower s_tvalid, collect every expected result, and then stay quiet long
        // enough that a stray extra result would still be caught.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mirror.pending() != 0) begin
            mirror.report_mismatch($sformatf("%0d expected results never arrived",
                                             mirror.pending()));
        end

        if (mirror.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
